### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared sizes, opcodes, sequencer states and the edge unit status bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic toggle;
  } edge_stat_t;

endpackage

### rtl/pip_edge.sv
// ----------------------------------------------------------------------------
// Point-in-polygon edge unit
// Two-stage pipeline that decides whether one edge toggles the inside flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_edge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   edge_valid,
  input  logic signed [pip_pkg::COORD_BITS-1:0]  xi,
  input  logic signed [pip_pkg::COORD_BITS-1:0]  yi,
  input  logic signed [pip_pkg::COORD_BITS-1:0]  xj,
  input  logic signed [pip_pkg::COORD_BITS-1:0]  yj,
  input  logic signed [pip_pkg::COORD_BITS-1:0]  px,
  input  logic signed [pip_pkg::COORD_BITS-1:0]  py,
  output pip_pkg::edge_stat_t                    stat
);

  localparam int C = pip_pkg::COORD_BITS;

  logic signed [C:0]     dxp_nxt, dy_nxt, dxe_nxt, dyp_nxt;
  logic signed [C:0]     dxp_r, dy_r, dxe_r, dyp_r;
  logic                  straddle;
  logic                  v1_r, neg1_r;
  logic                  v2_r, neg2_r;
  logic signed [2*C+1:0] lhs_r, rhs_r;
  logic                  hit;

  assign straddle = ((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi));
  assign dxp_nxt  = {px[C-1], px} - {xi[C-1], xi};
  assign dy_nxt   = {yj[C-1], yj} - {yi[C-1], yi};
  assign dxe_nxt  = {xj[C-1], xj} - {xi[C-1], xi};
  assign dyp_nxt  = {py[C-1], py} - {yi[C-1], yi};

  // Stage one: differences. Only straddling edges travel on as valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= edge_valid && straddle;
    end
  end

  always_ff @(posedge clk) begin
    dxp_r  <= dxp_nxt;
    dy_r   <= dy_nxt;
    dxe_r  <= dxe_nxt;
    dyp_r  <= dyp_nxt;
    neg1_r <= dy_nxt[C];
  end

  // Stage two: the two cross products, side by side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    lhs_r  <= dxp_r * dy_r;
    rhs_r  <= dxe_r * dyp_r;
    neg2_r <= neg1_r;
  end

  // A falling edge flips the sense of the comparison.
  assign hit = neg2_r ? (lhs_r > rhs_r) : (lhs_r < rhs_r);

  assign stat.toggle = v2_r && hit;
  assign stat.busy   = v1_r || v2_r;

endmodule

### rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Crossing-number test of a point against a stored polygon of vertices.
// ----------------------------------------------------------------------------
// A clear, an append or an unused opcode answers in the cycle after it is taken
// and leaves busy low, so such items can follow back to back. A query on a
// store of n vertices walks the vertex memory at one read per cycle through
// its single read port; the answer appears once the last edge has left the
// edge unit (in the cycle after the query is taken on an empty store) and busy
// stays high until then. Each item yields exactly one result, shown for one cycle
// with out_valid; the receiver cannot stall it, so it must take every strobe.
`timescale 1ns / 1ps

module point_in_polygon_test (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_opcode,
  input  logic signed [15:0]             in_x_coord,
  input  logic signed [15:0]             in_y_coord,
  output logic                           out_valid,
  output logic                           out_inside_res,
  output logic                           out_status
);

  localparam int C  = pip_pkg::COORD_BITS;
  localparam int AW = pip_pkg::ADDR_W;
  localparam int CW = pip_pkg::CNT_W;

  pip_pkg::state_t state_r, state_nxt;
  pip_pkg::op_t    op;
  pip_pkg::edge_stat_t estat;

  logic [2*C-1:0]        vtx_mem [pip_pkg::MAX_VERTICES];
  logic [2*C-1:0]        rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;

  logic [CW-1:0]         cnt_r, idx_r;
  logic signed [C-1:0]   px_r, py_r, prev_x_r, prev_y_r;
  logic signed [C-1:0]   in_x, in_y, cur_x, cur_y;
  logic                  rd_vld_r, rd_first_r;
  logic                  inside_r;
  logic                  out_valid_r, out_inside_r, out_status_r;
  logic                  accept, full, walk_last, done;

  assign op     = pip_pkg::op_t'(in_opcode);
  assign in_x   = in_x_coord[C-1:0];
  assign in_y   = in_y_coord[C-1:0];
  assign busy   = (state_r != pip_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(pip_pkg::MAX_VERTICES));
  assign wr_en  = accept && (op == pip_pkg::OP_APPEND) && !full;
  assign walk_last = (idx_r == cnt_r - CW'(1));
  assign cur_x  = rd_data_r[2*C-1:C];
  assign cur_y  = rd_data_r[C-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        if (accept && (op == pip_pkg::OP_QUERY) && (cnt_r != '0)) begin
          state_nxt = pip_pkg::ST_PRIME;
        end
      end
      pip_pkg::ST_PRIME: state_nxt = pip_pkg::ST_WALK;
      pip_pkg::ST_WALK: begin
        if (walk_last) begin
          state_nxt = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (done) begin
          state_nxt = pip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. The walk first fetches the last vertex so that the
  // closing edge is formed with vertex zero.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    done    = 1'b0;
    unique case (state_r)
      pip_pkg::ST_IDLE: ;
      pip_pkg::ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_r - CW'(1));
      end
      pip_pkg::ST_WALK: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[AW-1:0];
      end
      pip_pkg::ST_DRAIN: done = !rd_vld_r && !estat.busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pip_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Vertex memory: x in the upper half, y in the lower half.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_mem[cnt_r[AW-1:0]] <= {in_x, in_y};
    end
    if (rd_en) begin
      rd_data_r <= vtx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      inside_r   <= 1'b0;
    end else begin
      rd_vld_r   <= rd_en;
      rd_first_r <= (state_r == pip_pkg::ST_PRIME);
      if (accept && (op == pip_pkg::OP_CLEAR)) begin
        cnt_r <= '0;
      end else if (wr_en) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (accept) begin
        idx_r    <= '0;
        inside_r <= 1'b0;
      end else begin
        if (state_r == pip_pkg::ST_WALK) begin
          idx_r <= idx_r + CW'(1);
        end
        if (estat.toggle) begin
          inside_r <= !inside_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (rd_vld_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
  end

  pip_edge u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .edge_valid (rd_vld_r && !rd_first_r),
    .xi         (cur_x),
    .yi         (cur_y),
    .xj         (prev_x_r),
    .yj         (prev_y_r),
    .px         (px_r),
    .py         (py_r),
    .stat       (estat)
  );

  // Result register. Items that need no walk answer straight away.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && !((op == pip_pkg::OP_QUERY) && (cnt_r != '0)))
                     || done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_inside_r <= inside_r;
      out_status_r <= 1'b0;
    end else if (accept) begin
      out_inside_r <= 1'b0;
      out_status_r <= (op == pip_pkg::OP_APPEND) && full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_status     = out_status_r;

endmodule
